// ===== rtl/plis_pkg.sv =====
// Shared constants, types and codes of the piecewise-linear inverse-CDF sampler.
`timescale 1ns / 1ps
package plis_pkg;

   localparam int MAX_POINTS = 256;
   localparam int PTR_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [47:0] SLOPE_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [63:0] PROD_MAX = 64'h4000_0000_0000_0000;
   localparam logic [31:0] Y_MAX = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      STATUS_SAMPLE = 2'd0,
      STATUS_READY  = 2'd1,
      STATUS_REJECT = 2'd2,
      STATUS_NONE   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_CHK,
      MD_DIV
   } md_state_type;

   typedef enum logic {
      SQ_IDLE,
      SQ_RUN
   } sq_state_type;

   typedef enum logic [5:0] {
      S_IDLE,
      S_PR_START,
      S_PR_RD,
      S_PR_USE,
      S_PR_SLOPE,
      S_LEFT,
      S_LEFT_M,
      S_LEFT_SH,
      S_RIGHT,
      S_RIGHT_M,
      S_RIGHT_SH,
      S_WB0,
      S_WBL,
      S_CA_RD,
      S_CA_USE,
      S_CA_M,
      S_CA_LO,
      S_CA_HI,
      S_PA_M1,
      S_PA_M2,
      S_CA_NEXT,
      S_FIN,
      S_DR_FLAT,
      S_DR_SRCH,
      S_DR_CMP,
      S_DR_RD1,
      S_DR_RD2,
      S_DR_RD3,
      S_DR_Y2,
      S_DR_T,
      S_DR_SQ,
      S_DR_DX,
      S_DR_OUT
   } seq_state_type;

   typedef struct packed {
      logic        go;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] c;
   } md_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] q;
   } md_rsp_type;

   typedef struct packed {
      logic        go;
      logic [63:0] n;
   } sq_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] root;
   } sq_rsp_type;

endpackage

// ===== rtl/plis_muldiv.sv =====
// Shared multiply-divide unit: floor(a*b/c) by shift-add product and restoring division.
`timescale 1ns / 1ps
module plis_muldiv (
   input  logic                clock,
   input  logic                reset,
   input  plis_pkg::md_req_type md_req,
   output plis_pkg::md_rsp_type md_rsp
);
   import plis_pkg::*;

   md_state_type state_ff, state_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic [63:0]  a_ff, a_in;
   logic [63:0]  b_ff, b_in;
   logic [63:0]  c_ff, c_in;
   logic [127:0] acc_ff, acc_in;
   logic         done_ff, done_in;
   logic [64:0]  rem_sh;
   logic [64:0]  rem_sub;
   logic         ge;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      acc_ff <= acc_in;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      acc_in   = acc_ff;
      done_in  = 1'b0;
      rem_sh   = {acc_ff[127:64], acc_ff[63]};
      ge       = rem_sh >= {1'b0, c_ff};
      rem_sub  = rem_sh - {1'b0, c_ff};
      unique case (state_ff)
         MD_IDLE: begin
            if (md_req.go) begin
               a_in     = md_req.a;
               b_in     = md_req.b;
               c_in     = md_req.c;
               acc_in   = '0;
               cnt_in   = '0;
               state_in = MD_MUL;
            end
         end
         MD_MUL: begin
            acc_in = {acc_ff[126:0], 1'b0} + (a_ff[63] ? {64'd0, b_ff} : 128'd0);
            a_in   = {a_ff[62:0], 1'b0};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == '1) begin
               state_in = MD_CHK;
            end
         end
         MD_CHK: begin
            if (c_ff == '0 || acc_ff[127:64] >= c_ff) begin
               acc_in[63:0] = ONES;
               done_in      = 1'b1;
               state_in     = MD_IDLE;
            end else begin
               cnt_in   = '0;
               state_in = MD_DIV;
            end
         end
         MD_DIV: begin
            acc_in = {(ge ? rem_sub[63:0] : rem_sh[63:0]), acc_ff[62:0], ge};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == '1) begin
               done_in  = 1'b1;
               state_in = MD_IDLE;
            end
         end
         default: state_in = MD_IDLE;
      endcase
   end

   assign md_rsp.done = done_ff;
   assign md_rsp.q    = acc_ff[63:0];

endmodule

// ===== rtl/plis_isqrt.sv =====
// Bitwise integer square root of a 64-bit value, two bits of the radicand per cycle.
`timescale 1ns / 1ps
module plis_isqrt (
   input  logic                clock,
   input  logic                reset,
   input  plis_pkg::sq_req_type sq_req,
   output plis_pkg::sq_rsp_type sq_rsp
);
   import plis_pkg::*;

   sq_state_type state_ff, state_in;
   logic [63:0]  n_ff, n_in;
   logic [63:0]  r_ff, r_in;
   logic [63:0]  bit_ff, bit_in;
   logic         done_ff, done_in;
   logic [63:0]  trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      n_ff   <= n_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      r_in     = r_ff;
      bit_in   = bit_ff;
      done_in  = 1'b0;
      trial    = r_ff + bit_ff;
      unique case (state_ff)
         SQ_IDLE: begin
            if (sq_req.go) begin
               n_in     = sq_req.n;
               r_in     = '0;
               bit_in   = 64'h4000_0000_0000_0000;
               state_in = SQ_RUN;
            end
         end
         SQ_RUN: begin
            if (n_ff >= trial) begin
               n_in = n_ff - trial;
               r_in = {1'b0, r_ff[63:1]} + bit_ff;
            end else begin
               r_in = {1'b0, r_ff[63:1]};
            end
            bit_in = {2'b00, bit_ff[63:2]};
            if (bit_ff[0]) begin
               done_in  = 1'b1;
               state_in = SQ_IDLE;
            end
         end
         default: state_in = SQ_IDLE;
      endcase
   end

   assign sq_rsp.done = done_ff;
   assign sq_rsp.root = r_ff[31:0];

endmodule

// ===== rtl/piecewise_linear_inverse_cdf_sampler_unit.sv =====
// Top level: table memories, sequencer for loading, preparation and sampling, and the register port.
// A load without the last mark stays in the idle state; busy stays low and no result follows.
// Preparation forms each slope, segment area and partial area in turn on the multiply-divide unit.
// A sample uses up to four multiply-divides, a 32-step square root and a binary search whose
// probes each pass a search and a compare state. The result strobe cannot be stalled.
// Reset clears the control state, loads range low 0 and high 65536; table memories are not cleared.
`timescale 1ns / 1ps
module piecewise_linear_inverse_cdf_sampler_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_type,
   input  logic [31:0] req_point_x,
   input  logic [31:0] req_point_y,
   input  logic        req_last_point,
   input  logic [31:0] req_uniform,
   output logic        rsp_valid,
   output logic [31:0] rsp_sample_x,
   output logic [1:0]  rsp_status,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import plis_pkg::*;

   logic [31:0] x_mem [MAX_POINTS];
   logic [31:0] y_mem [MAX_POINTS];
   logic [47:0] sl_mem [MAX_POINTS];
   logic [63:0] cum_mem [MAX_POINTS];

   logic signed [31:0] x_q_ff;
   logic [31:0]        y_q_ff;
   logic signed [47:0] sl_q_ff;
   logic [63:0]        cum_q_ff;

   logic             xy_we, sl_we, cum_we;
   logic [PTR_W-1:0] xy_waddr, sl_waddr, cum_waddr, mem_addr, sl_raddr;
   logic [31:0]      x_wdata, y_wdata;
   logic [47:0]      sl_wdata;
   logic [63:0]      cum_wdata;

   md_req_type md_req;
   md_rsp_type md_rsp;
   sq_req_type sq_req;
   sq_rsp_type sq_rsp;

   seq_state_type      state_ff, state_in;
   logic [31:0]        range_low_ff, range_low_in, range_high_ff, range_high_in;
   logic [CNT_W-1:0]   count_ff, count_in, q_ff, q_in, i_ff, i_in;
   logic               ready_ff, ready_in;
   logic [63:0]        area_start_ff, area_start_in, area_active_ff, area_active_in;
   logic [PTR_W-1:0]   idx_start_ff, idx_start_in, idx_finish_ff, idx_finish_in;
   logic signed [31:0] lo_ff, lo_in, hi_ff, hi_in;
   logic signed [31:0] px_ff, px_in, cx_ff, cx_in, x0_ff, x0_in, xl_ff, xl_in;
   logic [31:0]        py_ff, py_in, cy_ff, cy_in, y0_ff, y0_in, yl_ff, yl_in;
   logic signed [47:0] s0_ff, s0_in, sl_ff, sl_in, ps_ff, ps_in;
   logic               neg_ff, neg_in, which_ff, which_in;
   logic [32:0]        d_ff, d_in;
   logic [63:0]        start_ff, start_in, fin_ff, fin_in, cum_ff, cum_in;
   logic [PTR_W-1:0]   ns_ff, ns_in, nf_ff, nf_in;
   logic [63:0]        flat_ff, flat_in, cum1_ff, cum1_in, dran_ff, dran_in;
   logic [63:0]        y2_ff, y2_in, tmp_ff, tmp_in;
   logic [PTR_W-1:0]   n1_ff, n1_in, n2_ff, n2_in, n3_ff, n3_in;
   logic signed [31:0] x1_ff, x1_in;
   logic [31:0]        y1_ff, y1_in;
   logic signed [47:0] a_ff, a_in;
   logic [32:0]        seg_ff, seg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_x_ff, rsp_x_in;
   status_type         rsp_status_ff, rsp_status_in;

   logic cfg_wr;

   function automatic logic [63:0] smag(input logic signed [47:0] s);
      logic [47:0] t;
      t = -s;
      return s[47] ? {16'd0, t} : {16'd0, s};
   endfunction

   function automatic logic [63:0] clip62(input logic [63:0] m);
      return (m > PROD_MAX) ? PROD_MAX : m;
   endfunction

   function automatic logic [32:0] xdiff(input logic signed [31:0] a,
                                         input logic signed [31:0] b);
      return {a[31], a} - {b[31], b};
   endfunction

   plis_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .md_rsp (md_rsp)
   );

   plis_isqrt u_isqrt (
      .clock  (clock),
      .reset  (reset),
      .sq_req (sq_req),
      .sq_rsp (sq_rsp)
   );

   always_ff @(posedge clock) begin
      if (xy_we) begin
         x_mem[xy_waddr] <= x_wdata;
         y_mem[xy_waddr] <= y_wdata;
      end
      x_q_ff <= x_mem[mem_addr];
      y_q_ff <= y_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (sl_we) begin
         sl_mem[sl_waddr] <= sl_wdata;
      end
      sl_q_ff <= sl_mem[sl_raddr];
   end

   always_ff @(posedge clock) begin
      if (cum_we) begin
         cum_mem[cum_waddr] <= cum_wdata;
      end
      cum_q_ff <= cum_mem[mem_addr];
   end

   assign cfg_wr = psel & penable & pwrite;
   assign pready = 1'b1;
   assign prdata = paddr[2] ? range_high_ff : range_low_ff;

   always_comb begin
      range_low_in  = range_low_ff;
      range_high_in = range_high_ff;
      if (cfg_wr) begin
         if (paddr[2]) begin
            range_high_in = pwdata;
         end else begin
            range_low_in = pwdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         range_low_ff   <= 32'd0;
         range_high_ff  <= 32'd65536;
         count_ff       <= '0;
         ready_ff       <= 1'b0;
         area_start_ff  <= '0;
         area_active_ff <= '0;
         idx_start_ff   <= '0;
         idx_finish_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         range_low_ff   <= range_low_in;
         range_high_ff  <= range_high_in;
         count_ff       <= count_in;
         ready_ff       <= ready_in;
         area_start_ff  <= area_start_in;
         area_active_ff <= area_active_in;
         idx_start_ff   <= idx_start_in;
         idx_finish_ff  <= idx_finish_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      q_ff          <= q_in;
      i_ff          <= i_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      px_ff         <= px_in;
      cx_ff         <= cx_in;
      x0_ff         <= x0_in;
      xl_ff         <= xl_in;
      py_ff         <= py_in;
      cy_ff         <= cy_in;
      y0_ff         <= y0_in;
      yl_ff         <= yl_in;
      s0_ff         <= s0_in;
      sl_ff         <= sl_in;
      ps_ff         <= ps_in;
      neg_ff        <= neg_in;
      which_ff      <= which_in;
      d_ff          <= d_in;
      start_ff      <= start_in;
      fin_ff        <= fin_in;
      cum_ff        <= cum_in;
      ns_ff         <= ns_in;
      nf_ff         <= nf_in;
      flat_ff       <= flat_in;
      cum1_ff       <= cum1_in;
      dran_ff       <= dran_in;
      y2_ff         <= y2_in;
      tmp_ff        <= tmp_in;
      n1_ff         <= n1_in;
      n2_ff         <= n2_in;
      n3_ff         <= n3_in;
      x1_ff         <= x1_in;
      y1_ff         <= y1_in;
      a_ff          <= a_in;
      seg_ff        <= seg_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      logic [32:0]        dyv;
      logic [32:0]        dymag;
      logic [63:0]        m;
      logic [63:0]        yn;
      logic [47:0]        sat;
      logic [32:0]        nx;
      logic [63:0]        pa;
      logic               pa_ready;
      logic [63:0]        cnew;
      logic [63:0]        t2;
      logic [63:0]        disc;
      logic [32:0]        den;
      logic [PTR_W-1:0]   ns_v;
      logic [63:0]        dx;
      logic [CNT_W-1:0]   newcount;

      state_in       = state_ff;
      count_in       = count_ff;
      ready_in       = ready_ff;
      area_start_in  = area_start_ff;
      area_active_in = area_active_ff;
      idx_start_in   = idx_start_ff;
      idx_finish_in  = idx_finish_ff;
      q_in           = q_ff;
      i_in           = i_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      px_in          = px_ff;
      cx_in          = cx_ff;
      x0_in          = x0_ff;
      xl_in          = xl_ff;
      py_in          = py_ff;
      cy_in          = cy_ff;
      y0_in          = y0_ff;
      yl_in          = yl_ff;
      s0_in          = s0_ff;
      sl_in          = sl_ff;
      ps_in          = ps_ff;
      neg_in         = neg_ff;
      which_in       = which_ff;
      d_in           = d_ff;
      start_in       = start_ff;
      fin_in         = fin_ff;
      cum_in         = cum_ff;
      ns_in          = ns_ff;
      nf_in          = nf_ff;
      flat_in        = flat_ff;
      cum1_in        = cum1_ff;
      dran_in        = dran_ff;
      y2_in          = y2_ff;
      tmp_in         = tmp_ff;
      n1_in          = n1_ff;
      n2_in          = n2_ff;
      n3_in          = n3_ff;
      x1_in          = x1_ff;
      y1_in          = y1_ff;
      a_in           = a_ff;
      seg_in         = seg_ff;
      rsp_valid_in   = 1'b0;
      rsp_x_in       = rsp_x_ff;
      rsp_status_in  = rsp_status_ff;

      xy_we     = 1'b0;
      xy_waddr  = count_ff[PTR_W-1:0];
      x_wdata   = req_point_x;
      y_wdata   = req_point_y;
      sl_we     = 1'b0;
      sl_waddr  = PTR_W'(i_ff - CNT_W'(1));
      sl_wdata  = '0;
      cum_we    = 1'b0;
      cum_waddr = i_ff[PTR_W-1:0];
      cum_wdata = '0;
      mem_addr  = i_ff[PTR_W-1:0];
      sl_raddr  = PTR_W'(i_ff - CNT_W'(1));
      md_req    = '0;
      sq_req    = '0;

      dyv      = {1'b0, y_q_ff} - {1'b0, py_ff};
      dymag    = dyv[32] ? -dyv : dyv;
      m        = clip62(md_rsp.q);
      yn       = '0;
      sat      = (md_rsp.q > {16'd0, SLOPE_MAX}) ? SLOPE_MAX : md_rsp.q[47:0];
      nx       = '0;
      pa       = '0;
      pa_ready = 1'b0;
      cnew     = cum_ff + md_rsp.q;
      t2       = md_rsp.q[63] ? ONES : {md_rsp.q[62:0], 1'b0};
      disc     = '0;
      den      = {1'b0, y1_ff} + {1'b0, sq_rsp.root};
      ns_v     = ns_ff;
      dx       = (tmp_ff > 64'(seg_ff)) ? 64'(seg_ff) : tmp_ff;
      newcount = (count_ff < CNT_W'(MAX_POINTS)) ? count_ff + CNT_W'(1) : count_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (!req_type) begin
                  if (count_ff == '0) begin
                     ready_in = 1'b0;
                  end
                  if (count_ff < CNT_W'(MAX_POINTS)) begin
                     xy_we = 1'b1;
                  end
                  count_in = newcount;
                  if (req_last_point) begin
                     q_in     = newcount;
                     count_in = '0;
                     lo_in    = range_low_ff;
                     hi_in    = range_high_ff;
                     state_in = S_PR_START;
                  end
               end else if (!ready_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_x_in      = '0;
                  rsp_status_in = STATUS_NONE;
               end else begin
                  md_req.go = 1'b1;
                  md_req.a  = area_active_ff;
                  md_req.b  = {32'd0, req_uniform};
                  md_req.c  = 64'h1_0000_0000;
                  state_in  = S_DR_FLAT;
               end
            end
         end

         S_PR_START: begin
            i_in = '0;
            if (q_ff < CNT_W'(2) || lo_ff >= hi_ff) begin
               ready_in      = 1'b0;
               rsp_valid_in  = 1'b1;
               rsp_x_in      = '0;
               rsp_status_in = STATUS_REJECT;
               state_in      = S_IDLE;
            end else begin
               state_in = S_PR_RD;
            end
         end

         S_PR_RD: begin
            state_in = S_PR_USE;
         end

         S_PR_USE: begin
            cx_in = x_q_ff;
            cy_in = y_q_ff;
            if (i_ff == '0) begin
               x0_in    = x_q_ff;
               y0_in    = y_q_ff;
               px_in    = x_q_ff;
               py_in    = y_q_ff;
               i_in     = CNT_W'(1);
               state_in = S_PR_RD;
            end else if (px_ff >= x_q_ff) begin
               ready_in      = 1'b0;
               rsp_valid_in  = 1'b1;
               rsp_x_in      = '0;
               rsp_status_in = STATUS_REJECT;
               state_in      = S_IDLE;
            end else begin
               neg_in    = dyv[32];
               md_req.go = 1'b1;
               md_req.a  = 64'(dymag);
               md_req.b  = 64'd65536;
               md_req.c  = 64'(xdiff(x_q_ff, px_ff));
               state_in  = S_PR_SLOPE;
            end
         end

         S_PR_SLOPE: begin
            if (md_rsp.done) begin
               sl_we    = 1'b1;
               sl_wdata = neg_ff ? -sat : sat;
               if (i_ff == CNT_W'(1)) begin
                  s0_in = sl_wdata;
               end
               sl_in = sl_wdata;
               px_in = cx_ff;
               py_in = cy_ff;
               xl_in = cx_ff;
               yl_in = cy_ff;
               i_in  = i_ff + CNT_W'(1);
               if ((i_ff + CNT_W'(1)) < q_ff) begin
                  state_in = S_PR_RD;
               end else begin
                  state_in = S_LEFT;
               end
            end
         end

         S_LEFT: begin
            if (lo_ff < x0_ff) begin
               d_in      = xdiff(x0_ff, lo_ff);
               md_req.go = 1'b1;
               md_req.a  = smag(s0_ff);
               md_req.b  = 64'(xdiff(x0_ff, lo_ff));
               md_req.c  = 64'd65536;
               state_in  = S_LEFT_M;
            end else begin
               state_in = S_RIGHT;
            end
         end

         S_LEFT_M: begin
            if (md_rsp.done) begin
               if (!s0_ff[47] && m > 64'(y0_ff)) begin
                  md_req.go = 1'b1;
                  md_req.a  = 64'(y0_ff);
                  md_req.b  = 64'd65536;
                  md_req.c  = smag(s0_ff);
                  state_in  = S_LEFT_SH;
               end else begin
                  yn       = s0_ff[47] ? 64'(y0_ff) + m : 64'(y0_ff) - m;
                  y0_in    = (yn > 64'(Y_MAX)) ? Y_MAX : yn[31:0];
                  x0_in    = lo_ff;
                  state_in = S_RIGHT;
               end
            end
         end

         S_LEFT_SH: begin
            if (md_rsp.done) begin
               nx = (md_rsp.q > 64'(d_ff)) ? {lo_ff[31], lo_ff}
                                          : {x0_ff[31], x0_ff} - md_rsp.q[32:0];
               if (hi_ff < $signed(nx[31:0])) begin
                  ready_in      = 1'b0;
                  rsp_valid_in  = 1'b1;
                  rsp_x_in      = '0;
                  rsp_status_in = STATUS_REJECT;
                  state_in      = S_IDLE;
               end else begin
                  lo_in    = nx[31:0];
                  x0_in    = nx[31:0];
                  y0_in    = '0;
                  state_in = S_RIGHT;
               end
            end
         end

         S_RIGHT: begin
            if (hi_ff > xl_ff) begin
               d_in      = xdiff(hi_ff, xl_ff);
               md_req.go = 1'b1;
               md_req.a  = smag(sl_ff);
               md_req.b  = 64'(xdiff(hi_ff, xl_ff));
               md_req.c  = 64'd65536;
               state_in  = S_RIGHT_M;
            end else begin
               state_in = S_WB0;
            end
         end

         S_RIGHT_M: begin
            if (md_rsp.done) begin
               if (sl_ff[47] && m > 64'(yl_ff)) begin
                  md_req.go = 1'b1;
                  md_req.a  = 64'(yl_ff);
                  md_req.b  = 64'd65536;
                  md_req.c  = smag(sl_ff);
                  state_in  = S_RIGHT_SH;
               end else begin
                  yn       = sl_ff[47] ? 64'(yl_ff) - m : 64'(yl_ff) + m;
                  yl_in    = (yn > 64'(Y_MAX)) ? Y_MAX : yn[31:0];
                  xl_in    = hi_ff;
                  state_in = S_WB0;
               end
            end
         end

         S_RIGHT_SH: begin
            if (md_rsp.done) begin
               nx = (md_rsp.q > 64'(d_ff)) ? {hi_ff[31], hi_ff}
                                          : {xl_ff[31], xl_ff} + md_rsp.q[32:0];
               if (lo_ff > $signed(nx[31:0])) begin
                  ready_in      = 1'b0;
                  rsp_valid_in  = 1'b1;
                  rsp_x_in      = '0;
                  rsp_status_in = STATUS_REJECT;
                  state_in      = S_IDLE;
               end else begin
                  hi_in    = nx[31:0];
                  xl_in    = nx[31:0];
                  yl_in    = '0;
                  state_in = S_WB0;
               end
            end
         end

         S_WB0: begin
            xy_we    = 1'b1;
            xy_waddr = '0;
            x_wdata  = x0_ff;
            y_wdata  = y0_ff;
            state_in = S_WBL;
         end

         S_WBL: begin
            xy_we     = 1'b1;
            xy_waddr  = PTR_W'(q_ff - CNT_W'(1));
            x_wdata   = xl_ff;
            y_wdata   = yl_ff;
            cum_we    = 1'b1;
            cum_waddr = '0;
            cum_wdata = '0;
            cum_in    = '0;
            start_in  = '0;
            fin_in    = '0;
            ns_in     = '0;
            nf_in     = '0;
            i_in      = '0;
            state_in  = S_CA_RD;
         end

         S_CA_RD: begin
            state_in = S_CA_USE;
         end

         S_CA_USE: begin
            cx_in = x_q_ff;
            cy_in = y_q_ff;
            ps_in = sl_q_ff;
            if (i_ff == '0) begin
               px_in    = x_q_ff;
               py_in    = y_q_ff;
               i_in     = CNT_W'(1);
               state_in = S_CA_RD;
            end else begin
               md_req.go = 1'b1;
               md_req.a  = 64'(xdiff(x_q_ff, px_ff));
               md_req.b  = 64'({1'b0, py_ff} + {1'b0, y_q_ff});
               md_req.c  = 64'd131072;
               state_in  = S_CA_M;
            end
         end

         S_CA_M: begin
            if (md_rsp.done) begin
               cum_we    = 1'b1;
               cum_wdata = cnew;
               cum_in    = cnew;
               state_in  = S_CA_LO;
            end
         end

         S_CA_LO: begin
            if (lo_ff >= cx_ff) begin
               start_in = cum_ff;
               ns_in    = i_ff[PTR_W-1:0];
               state_in = S_CA_HI;
            end else if (lo_ff > px_ff) begin
               which_in  = 1'b0;
               d_in      = xdiff(lo_ff, px_ff);
               md_req.go = 1'b1;
               md_req.a  = smag(ps_ff);
               md_req.b  = 64'(xdiff(lo_ff, px_ff));
               md_req.c  = 64'd131072;
               state_in  = S_PA_M1;
            end else begin
               state_in = S_CA_HI;
            end
         end

         S_CA_HI: begin
            if (hi_ff >= cx_ff) begin
               fin_in   = cum_ff;
               nf_in    = i_ff[PTR_W-1:0];
               state_in = S_CA_NEXT;
            end else if (hi_ff > px_ff) begin
               which_in  = 1'b1;
               d_in      = xdiff(hi_ff, px_ff);
               md_req.go = 1'b1;
               md_req.a  = smag(ps_ff);
               md_req.b  = 64'(xdiff(hi_ff, px_ff));
               md_req.c  = 64'd131072;
               state_in  = S_PA_M1;
            end else begin
               state_in = S_CA_NEXT;
            end
         end

         S_PA_M1: begin
            if (md_rsp.done) begin
               if (ps_ff[47]) begin
                  yn = 64'(py_ff) - m;
                  if (m < 64'(py_ff)) begin
                     md_req.go = 1'b1;
                  end
               end else begin
                  yn = 64'(py_ff) + m;
                  if (yn != '0) begin
                     md_req.go = 1'b1;
                  end
               end
               md_req.a = 64'(d_ff);
               md_req.b = yn;
               md_req.c = 64'd65536;
               if (md_req.go) begin
                  state_in = S_PA_M2;
               end else begin
                  pa_ready = 1'b1;
               end
            end
         end

         S_PA_M2: begin
            if (md_rsp.done) begin
               pa       = md_rsp.q;
               pa_ready = 1'b1;
            end
         end

         S_CA_NEXT: begin
            px_in = cx_ff;
            py_in = cy_ff;
            i_in  = i_ff + CNT_W'(1);
            if ((i_ff + CNT_W'(1)) < q_ff) begin
               state_in = S_CA_RD;
            end else begin
               state_in = S_FIN;
            end
         end

         S_FIN: begin
            rsp_valid_in = 1'b1;
            rsp_x_in     = '0;
            if (cum_ff == '0) begin
               ready_in      = 1'b0;
               rsp_status_in = STATUS_REJECT;
            end else begin
               if (nf_ff <= ns_ff) begin
                  if (CNT_W'(ns_ff) >= q_ff - CNT_W'(1)) begin
                     ns_v = PTR_W'(q_ff - CNT_W'(2));
                  end
                  idx_start_in  = ns_v;
                  idx_finish_in = ns_v + PTR_W'(1);
               end else begin
                  idx_start_in  = ns_ff;
                  idx_finish_in = nf_ff;
               end
               area_start_in  = start_ff;
               area_active_in = (fin_ff > start_ff) ? fin_ff - start_ff : '0;
               ready_in       = 1'b1;
               rsp_status_in  = STATUS_READY;
            end
            state_in = S_IDLE;
         end

         S_DR_FLAT: begin
            if (md_rsp.done) begin
               flat_in  = area_start_ff + md_rsp.q;
               n1_in    = idx_start_ff;
               n2_in    = idx_finish_ff;
               state_in = S_DR_SRCH;
            end
         end

         S_DR_SRCH: begin
            if ((n2_ff - n1_ff) > PTR_W'(1)) begin
               n3_in    = n1_ff + ((n2_ff - n1_ff) >> 1);
               mem_addr = n1_ff + ((n2_ff - n1_ff) >> 1);
               state_in = S_DR_CMP;
            end else begin
               state_in = S_DR_RD1;
            end
         end

         S_DR_CMP: begin
            if (flat_ff < cum_q_ff) begin
               n2_in = n3_ff;
            end else begin
               n1_in = n3_ff;
            end
            state_in = S_DR_SRCH;
         end

         S_DR_RD1: begin
            mem_addr = n1_ff;
            sl_raddr = n1_ff;
            state_in = S_DR_RD2;
         end

         S_DR_RD2: begin
            cum1_in  = cum_q_ff;
            x1_in    = x_q_ff;
            y1_in    = y_q_ff;
            a_in     = sl_q_ff;
            dran_in  = (flat_ff >= cum_q_ff) ? flat_ff - cum_q_ff : '0;
            mem_addr = n2_ff;
            state_in = S_DR_RD3;
         end

         S_DR_RD3: begin
            seg_in = xdiff(x_q_ff, x1_ff);
            if (a_ff != '0) begin
               md_req.go = 1'b1;
               md_req.a  = 64'(y1_ff);
               md_req.b  = 64'(y1_ff);
               md_req.c  = 64'd1;
               state_in  = S_DR_Y2;
            end else begin
               yn = (cum_q_ff > cum1_ff) ? cum_q_ff - cum1_ff : '0;
               if (yn != '0) begin
                  md_req.go = 1'b1;
                  md_req.a  = 64'(xdiff(x_q_ff, x1_ff));
                  md_req.b  = dran_ff;
                  md_req.c  = yn;
                  state_in  = S_DR_DX;
               end else begin
                  tmp_in   = '0;
                  state_in = S_DR_OUT;
               end
            end
         end

         S_DR_Y2: begin
            if (md_rsp.done) begin
               y2_in     = md_rsp.q;
               md_req.go = 1'b1;
               md_req.a  = smag(a_ff);
               md_req.b  = dran_ff;
               md_req.c  = 64'd1;
               state_in  = S_DR_T;
            end
         end

         S_DR_T: begin
            if (md_rsp.done) begin
               if (!a_ff[47]) begin
                  disc = (y2_ff > ~t2) ? ONES : y2_ff + t2;
               end else begin
                  disc = (y2_ff > t2) ? y2_ff - t2 : '0;
               end
               sq_req.go = 1'b1;
               sq_req.n  = disc;
               state_in  = S_DR_SQ;
            end
         end

         S_DR_SQ: begin
            if (sq_rsp.done) begin
               if (den != '0) begin
                  md_req.go = 1'b1;
                  md_req.a  = dran_ff;
                  md_req.b  = 64'd131072;
                  md_req.c  = 64'(den);
                  state_in  = S_DR_DX;
               end else begin
                  tmp_in   = '0;
                  state_in = S_DR_OUT;
               end
            end
         end

         S_DR_DX: begin
            if (md_rsp.done) begin
               tmp_in   = md_rsp.q;
               state_in = S_DR_OUT;
            end
         end

         S_DR_OUT: begin
            rsp_valid_in  = 1'b1;
            rsp_x_in      = x1_ff + dx[31:0];
            rsp_status_in = STATUS_SAMPLE;
            state_in      = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase

      if (pa_ready) begin
         if (!which_ff) begin
            start_in = start_ff + pa;
            ns_in    = PTR_W'(i_ff - CNT_W'(1));
            state_in = S_CA_HI;
         end else begin
            fin_in   = fin_ff + pa;
            nf_in    = i_ff[PTR_W-1:0];
            state_in = S_CA_NEXT;
         end
      end
   end

   assign busy         = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_sample_x = rsp_x_ff;
   assign rsp_status   = rsp_status_ff;

endmodule
